FILE: design/dctc_pkg.sv
`timescale 1ns / 1ps

package dctc_pkg;

    localparam int IVL_W          = 24;
    localparam int SPEED_W        = 8;
    localparam int CFG_IDX_W      = 8;
    localparam int STATE_W        = 3;
    localparam int TIMER_BITS_DEF = 24;
    localparam int TIMER_BITS_MAX = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_IVL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_IVL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_IVL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_SPD  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_EN   = 8'd4;

    // Reported state codes
    localparam logic [STATE_W-1:0] CODE_CLOSED  = 3'd0;
    localparam logic [STATE_W-1:0] CODE_OPENED  = 3'd1;
    localparam logic [STATE_W-1:0] CODE_NOTIFY  = 3'd2;
    localparam logic [STATE_W-1:0] CODE_CLOSING = 3'd3;
    localparam logic [STATE_W-1:0] CODE_STUCK   = 3'd4;

    typedef enum logic [4:0] {
        MODE_CLOSED  = 5'b00001,
        MODE_OPENED  = 5'b00010,
        MODE_NOTIFY  = 5'b00100,
        MODE_CLOSING = 5'b01000,
        MODE_STUCK   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [IVL_W-1:0]   open_ivl;
        logic [IVL_W-1:0]   notify_ivl;
        logic [IVL_W-1:0]   close_ivl;
        logic [SPEED_W-1:0] close_duty;
        logic               sound_en;
    } cfg_t;

    function automatic logic [STATE_W-1:0] mode_code(input mode_t mode);
        logic [STATE_W-1:0] code;
        case (mode)
            MODE_CLOSED:  code = CODE_CLOSED;
            MODE_OPENED:  code = CODE_OPENED;
            MODE_NOTIFY:  code = CODE_NOTIFY;
            MODE_CLOSING: code = CODE_CLOSING;
            MODE_STUCK:   code = CODE_STUCK;
            default:      code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

FILE: design/dctc_cfg.sv
`timescale 1ns / 1ps

module dctc_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dctc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dctc_pkg::IVL_W-1:0]        cfg_data,
    output dctc_pkg::cfg_t                    cfg
);

    dctc_pkg::cfg_t cfg_reg;
    dctc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dctc_pkg::REG_OPEN_IVL:   cfg_next.open_ivl    = cfg_data;
                dctc_pkg::REG_NOTIFY_IVL: cfg_next.notify_ivl  = cfg_data;
                dctc_pkg::REG_CLOSE_IVL:  cfg_next.close_ivl   = cfg_data;
                dctc_pkg::REG_MOTOR_SPD:
                    cfg_next.close_duty = cfg_data[dctc_pkg::SPEED_W-1:0];
                dctc_pkg::REG_SOUND_EN:   cfg_next.sound_en    = cfg_data[0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_ivl    <= 24'd10000;
            cfg_reg.notify_ivl  <= 24'd5000;
            cfg_reg.close_ivl   <= 24'd5000;
            cfg_reg.close_duty  <= 8'd200;
            cfg_reg.sound_en    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/door_close_timeout_controller.sv
`timescale 1ns / 1ps
// Latency: a tick accepted at one edge shows its result beat from the next cycle on.
// Throughput: one tick per cycle; the result register frees as its beat leaves, so
// s_ready stays high while m_ready is high. The single state/countdown update sets it.
// Reset (aresetn low, synchronous): closed, countdown zero, alarm clear, no result
// pending, configuration registers back to their defaults.
module door_close_timeout_controller #(
    parameter int TIMER_BITS = dctc_pkg::TIMER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_door_closed_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dctc_pkg::STATE_W-1:0]        m_door_state,
    output logic [dctc_pkg::SPEED_W-1:0]        m_motor_duty,
    output logic                                m_buzzer_on,
    output logic                                m_alarm_flag,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dctc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dctc_pkg::IVL_W-1:0]          cfg_data
);

    localparam int W = dctc_pkg::TIMER_BITS_MAX;
    localparam logic [W-1:0] TIMER_MAX = {W{1'b1}} >> (W - TIMER_BITS);

    dctc_pkg::cfg_t cfg;

    dctc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dctc_pkg::mode_t           mode_reg, mode_next;
    logic [TIMER_BITS-1:0]     cnt_reg, cnt_next;
    logic                      alarm_reg, alarm_next;
    logic                      out_valid_reg;
    logic [dctc_pkg::STATE_W-1:0] state_reg;
    logic [dctc_pkg::SPEED_W-1:0] duty_reg;
    logic                      buzz_reg;
    logic                      accept;

    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [dctc_pkg::IVL_W-1:0] ivl);
        logic [W-1:0] ext;
        ext = {{(W - dctc_pkg::IVL_W){1'b0}}, ivl};
        if (ext > TIMER_MAX) begin
            ext = TIMER_MAX;
        end
        return ext[TIMER_BITS-1:0];
    endfunction

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        alarm_next = alarm_reg;
        case (mode_reg)
            dctc_pkg::MODE_CLOSED: begin
                if (!s_door_closed_level) begin
                    mode_next = dctc_pkg::MODE_OPENED;
                    cnt_next  = sat_load(cfg.open_ivl);
                end
            end
            dctc_pkg::MODE_OPENED, dctc_pkg::MODE_NOTIFY, dctc_pkg::MODE_CLOSING: begin
                if (s_door_closed_level) begin
                    mode_next  = dctc_pkg::MODE_CLOSED;
                    alarm_next = 1'b0;
                end else if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - 1'b1;
                end else if (mode_reg == dctc_pkg::MODE_OPENED) begin
                    mode_next = dctc_pkg::MODE_NOTIFY;
                    cnt_next  = sat_load(cfg.notify_ivl);
                end else if (mode_reg == dctc_pkg::MODE_NOTIFY) begin
                    mode_next = dctc_pkg::MODE_CLOSING;
                    cnt_next  = sat_load(cfg.close_ivl);
                end else begin
                    mode_next  = dctc_pkg::MODE_STUCK;
                    alarm_next = 1'b1;
                end
            end
            dctc_pkg::MODE_STUCK: begin
                if (s_door_closed_level) begin
                    mode_next  = dctc_pkg::MODE_CLOSED;
                    alarm_next = 1'b0;
                end
            end
            default: begin
                mode_next  = dctc_pkg::MODE_CLOSED;
                alarm_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= dctc_pkg::MODE_CLOSED;
            cnt_reg       <= '0;
            alarm_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                alarm_reg <= alarm_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload follows the post-update state of each accepted tick
    always_ff @(posedge aclk) begin
        if (accept) begin
            state_reg <= dctc_pkg::mode_code(mode_next);
            duty_reg  <= (mode_next == dctc_pkg::MODE_CLOSING) ? cfg.close_duty : '0;
            buzz_reg  <= cfg.sound_en && ((mode_next == dctc_pkg::MODE_NOTIFY) ||
                                          (mode_next == dctc_pkg::MODE_STUCK));
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_door_state = state_reg;
    assign m_motor_duty = duty_reg;
    assign m_buzzer_on  = buzz_reg;
    assign m_alarm_flag = alarm_reg;

endmodule

FILE: design/dctc_checker.sv
`timescale 1ns / 1ps

module dctc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_door_closed_level,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [dctc_pkg::STATE_W-1:0]     m_door_state,
    input logic [dctc_pkg::SPEED_W-1:0]     m_motor_duty,
    input logic                             m_buzzer_on,
    input logic                             m_alarm_flag
);

    // A closed sensor level always lands in closed with the alarm cleared
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_door_closed_level |=>
            m_valid && (m_door_state == dctc_pkg::CODE_CLOSED) && !m_alarm_flag)
        else $error("closed level did not yield closed state with alarm clear");

    a_stuck_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_door_state == dctc_pkg::CODE_STUCK) |-> m_alarm_flag)
        else $error("stuck state without alarm");

    a_motor_only_closing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_motor_duty != '0) |-> (m_door_state == dctc_pkg::CODE_CLOSING))
        else $error("motor driven outside closing");

    a_buzzer_states: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_buzzer_on |->
            (m_door_state == dctc_pkg::CODE_NOTIFY) || (m_door_state == dctc_pkg::CODE_STUCK))
        else $error("buzzer on outside notify or stuck");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_door_state) && $stable(m_motor_duty)
            && $stable(m_buzzer_on) && $stable(m_alarm_flag))
        else $error("stalled result beat changed");

endmodule

bind door_close_timeout_controller dctc_checker u_dctc_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dctc_pkg::*;

    localparam int          CLK_PERIOD      = 20;
    localparam int          RESET_CYCLES    = 10;
    localparam int          TB_TIMER_BITS   = TIMER_BITS_DEF;
    localparam int          PHASES          = 9;
    localparam int          TICKS_PER_PHASE = 112;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          REPORT_LIMIT    = 10;

    localparam logic [31:0] TIMER_MAX = (TB_TIMER_BITS >= 32) ? 32'hFFFF_FFFF
                                        : ((32'd1 << TB_TIMER_BITS) - 32'd1);

    // indexes past the register list; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    localparam logic [IVL_W-1:0]   OPEN_IVL_RST   = 24'd10000;
    localparam logic [IVL_W-1:0]   NOTIFY_IVL_RST = 24'd5000;
    localparam logic [IVL_W-1:0]   CLOSE_IVL_RST  = 24'd5000;
    localparam logic [SPEED_W-1:0] SPEED_RST      = 8'd200;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [SPEED_W-1:0] duty;
        logic               buzzer;
        logic               alarm;
    } door_report_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [IVL_W-1:0]     data;
        logic                 level;
        bit                   typed;
        door_report_t         want;
    } door_step_t;

    localparam door_report_t NO_WANT = '0;

    logic                 aclk                = 1'b0;
    logic                 aresetn             = 1'b0;
    logic                 s_valid             = 1'b0;
    logic                 s_ready;
    logic                 s_door_closed_level = 1'b0;
    logic                 m_valid;
    logic                 m_ready             = 1'b0;
    logic [STATE_W-1:0]   m_door_state;
    logic [SPEED_W-1:0]   m_motor_duty;
    logic                 m_buzzer_on;
    logic                 m_alarm_flag;
    logic                 cfg_valid           = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index           = '0;
    logic [IVL_W-1:0]     cfg_data            = '0;

    // tracked copy of the block
    logic [IVL_W-1:0]         open_ivl      = OPEN_IVL_RST;
    logic [IVL_W-1:0]         notify_ivl    = NOTIFY_IVL_RST;
    logic [IVL_W-1:0]         close_ivl     = CLOSE_IVL_RST;
    logic [SPEED_W-1:0]       speed_reg     = SPEED_RST;
    logic                     sound_on      = 1'b1;
    logic [STATE_W-1:0]       door_code     = CODE_CLOSED;
    logic [TB_TIMER_BITS-1:0] count_left    = '0;
    logic                     alarm_latched = 1'b0;

    door_report_t door_reports_due [$];
    door_step_t   door_plan [$];

    bit           tick_typed = 1'b0;
    door_report_t tick_want  = NO_WANT;
    int unsigned  tick_gap_pct     = 0;
    int unsigned  report_stall_pct = 0;
    int unsigned  bad_beats        = 0;
    int unsigned  cycle_count      = 0;

    door_close_timeout_controller #(
        .TIMER_BITS(TB_TIMER_BITS)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_door_closed_level(s_door_closed_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_door_state       (m_door_state),
        .m_motor_duty       (m_motor_duty),
        .m_buzzer_on        (m_buzzer_on),
        .m_alarm_flag       (m_alarm_flag),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= report_stall_pct);

    function automatic logic [TB_TIMER_BITS-1:0] clamp_count(input logic [IVL_W-1:0] ivl);
        logic [31:0] wide;
        wide = {{(32 - IVL_W){1'b0}}, ivl};
        if (wide > TIMER_MAX) wide = TIMER_MAX;
        return TB_TIMER_BITS'(wide);
    endfunction

    function automatic void enter_door_state(input logic [STATE_W-1:0] nxt);
        case (nxt)
            CODE_OPENED:  count_left = clamp_count(open_ivl);
            CODE_NOTIFY:  count_left = clamp_count(notify_ivl);
            CODE_CLOSING: count_left = clamp_count(close_ivl);
            CODE_STUCK:   alarm_latched = 1'b1;
            default:      alarm_latched = 1'b0;
        endcase
        door_code = nxt;
    endfunction

    function automatic door_report_t advance_door(input logic closed_lvl);
        door_report_t r;
        if (door_code != CODE_CLOSED && closed_lvl) begin
            enter_door_state(CODE_CLOSED);
        end else if (door_code == CODE_CLOSED && !closed_lvl) begin
            enter_door_state(CODE_OPENED);
        end else if (door_code inside {CODE_OPENED, CODE_NOTIFY, CODE_CLOSING}) begin
            if (count_left == '0) enter_door_state(door_code + 1'b1);
            else count_left = count_left - 1'b1;
        end
        r.state  = door_code;
        r.duty   = (door_code == CODE_CLOSING) ? speed_reg : '0;
        r.buzzer = (door_code == CODE_NOTIFY || door_code == CODE_STUCK) && sound_on;
        r.alarm  = alarm_latched;
        return r;
    endfunction

    function automatic logic [IVL_W-1:0] pick_interval();
        if ($urandom_range(7) == 0) return IVL_W'($urandom);
        return IVL_W'($urandom_range(10));
    endfunction

    // pop results, track config, queue what each accepted tick should report
    always @(posedge aclk) begin : scoreboard
        door_report_t got;
        door_report_t want;
        door_report_t calc;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_door_state, m_motor_duty, m_buzzer_on, m_alarm_flag};
                if (door_reports_due.size() == 0) begin
                    if (bad_beats < REPORT_LIMIT)
                        $display("unexpected result beat: state %0d duty %0d buz %0b alarm %0b",
                                 got.state, got.duty, got.buzzer, got.alarm);
                    bad_beats++;
                end else begin
                    want = door_reports_due.pop_front();
                    if (got.state !== want.state || got.duty !== want.duty ||
                        got.buzzer !== want.buzzer || got.alarm !== want.alarm) begin
                        if (bad_beats < REPORT_LIMIT) begin
                            $write("beat mismatch: exp state %0d duty %0d buz %0b alarm %0b, ",
                                   want.state, want.duty, want.buzzer, want.alarm);
                            $display("got state %0d duty %0d buz %0b alarm %0b",
                                     got.state, got.duty, got.buzzer, got.alarm);
                        end
                        bad_beats++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OPEN_IVL:   open_ivl   = cfg_data;
                    REG_NOTIFY_IVL: notify_ivl = cfg_data;
                    REG_CLOSE_IVL:  close_ivl  = cfg_data;
                    REG_MOTOR_SPD:  speed_reg  = cfg_data[SPEED_W-1:0];
                    REG_SOUND_EN:   sound_on   = cfg_data[0];
                    default:        ;
                endcase
            end
            if (s_valid && s_ready) begin
                calc = advance_door(s_door_closed_level);
                door_reports_due.push_back(tick_typed ? tick_want : calc);
            end
        end
    end

    task automatic send_tick(input logic lvl, input bit typed, input door_report_t want);
        if ($urandom_range(99) < tick_gap_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < tick_gap_pct);
        end
        s_valid             <= 1'b1;
        s_door_closed_level <= lvl;
        tick_typed = typed;
        tick_want  = want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // drop valid and wait until every queued report has left, plus slack
    task automatic settle_block();
        s_valid <= 1'b0;
        while (door_reports_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        logic [IVL_W-1:0] o_ivl;
        logic [IVL_W-1:0] n_ivl;
        logic [IVL_W-1:0] c_ivl;
        logic [IVL_W-1:0] spd;
        logic [IVL_W-1:0] snd;
        int unsigned      run_cap;
        int unsigned      run_len;
        int unsigned      sent;

        door_plan = '{
            '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{CODE_CLOSED, 8'd0, 1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_OPENED, 8'd0, 1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{CODE_CLOSED, 8'd0, 1'b0, 1'b0}},
            '{ROW_CFG, REG_OPEN_IVL,   24'd0,       1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_NOTIFY_IVL, 24'd0,       1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_CLOSE_IVL,  24'd0,       1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_MOTOR_SPD,  24'hFFFFFF,  1'b0, 1'b0, NO_WANT},
            // zero intervals: one tick per timed state, then stuck holds
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_OPENED,  8'd0,   1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_NOTIFY,  8'd0,   1'b1, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_CLOSING, 8'd255, 1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_STUCK,   8'd0,   1'b1, 1'b1}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_STUCK,   8'd0,   1'b1, 1'b1}},
            '{ROW_CFG, REG_SOUND_EN, 24'hFFFFFE, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_STUCK,   8'd0,   1'b0, 1'b1}},
            '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{CODE_CLOSED,  8'd0,   1'b0, 1'b0}},
            '{ROW_CFG, REG_UNUSED_LO, 24'hFFFFFF, 1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_UNUSED_HI, 24'd0,      1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_OPENED,  8'd0,   1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_NOTIFY,  8'd0,   1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{CODE_CLOSING, 8'd255, 1'b0, 1'b0}},
            '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{CODE_CLOSED,  8'd0,   1'b0, 1'b0}},
            '{ROW_CFG, REG_SOUND_EN,   24'd1,      1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_MOTOR_SPD,  24'd0,      1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_OPEN_IVL,   24'hFFFFFF, 1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_NOTIFY_IVL, 24'd2,      1'b0, 1'b0, NO_WANT},
            '{ROW_CFG, REG_CLOSE_IVL,  24'd1,      1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b1, 1'b0, NO_WANT},
            '{ROW_CFG, REG_OPEN_IVL,   24'd1,      1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b0, 1'b0, NO_WANT},
            '{ROW_TICK, '0, '0, 1'b1, 1'b0, NO_WANT}
        };

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tick_gap_pct     = 33;
        report_stall_pct = 79;
        foreach (door_plan[i]) begin
            if (door_plan[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(door_plan[i].idx, door_plan[i].data);
            end else begin
                send_tick(door_plan[i].level, door_plan[i].typed, door_plan[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase % 3)
                0: begin
                    tick_gap_pct     = 33;
                    report_stall_pct = 79;
                end
                1: begin
                    tick_gap_pct     = 79;
                    report_stall_pct = 33;
                end
                default: begin
                    tick_gap_pct     = 0;
                    report_stall_pct = 0;
                end
            endcase
            case (phase)
                0: begin
                    o_ivl = '0;
                    n_ivl = '0;
                    c_ivl = '0;
                    spd   = 24'h000000;
                    snd   = 24'hFFFFFE;
                end
                1: begin
                    o_ivl = '1;
                    n_ivl = '1;
                    c_ivl = '1;
                    spd   = 24'hFFFFFF;
                    snd   = 24'h000001;
                end
                2: begin
                    o_ivl = '0;
                    n_ivl = '0;
                    c_ivl = '1;
                    spd   = IVL_W'($urandom);
                    snd   = IVL_W'($urandom);
                end
                default: begin
                    o_ivl = pick_interval();
                    n_ivl = pick_interval();
                    c_ivl = pick_interval();
                    spd   = IVL_W'($urandom);
                    snd   = IVL_W'($urandom);
                end
            endcase
            write_reg(REG_OPEN_IVL, o_ivl);
            write_reg(REG_NOTIFY_IVL, n_ivl);
            write_reg(REG_CLOSE_IVL, c_ivl);
            write_reg(REG_MOTOR_SPD, spd);
            write_reg(REG_SOUND_EN, snd);

            run_cap = o_ivl + n_ivl + c_ivl + 6;
            if (run_cap > 60) run_cap = 60;
            sent = 0;
            while (sent < TICKS_PER_PHASE) begin
                if ($urandom_range(9) == 0) begin
                    send_tick(1'($urandom_range(1)), 1'b0, NO_WANT);
                    sent++;
                end else begin
                    // hold the door open for a while, then close it
                    run_len = $urandom_range(run_cap, 1);
                    repeat (run_len) send_tick(1'b0, 1'b0, NO_WANT);
                    sent += run_len;
                    run_len = $urandom_range(3, 1);
                    repeat (run_len) send_tick(1'b1, 1'b0, NO_WANT);
                    sent += run_len;
                end
            end
        end

        settle_block();
        if (door_reports_due.size() != 0) begin
            if (bad_beats < REPORT_LIMIT)
                $display("%0d expected result beats never arrived", door_reports_due.size());
            bad_beats++;
        end
        if (bad_beats == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
